### design/rrsb_pkg.sv
// ----------------------------------------------------------------------------
// rrsb_pkg: shared types and constants for the round-robin shared bus
// Request and response payloads, status codes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package rrsb_pkg;

   localparam int MAX_ROUTERS_DEF = 16;
   localparam int NUM_W           = 5;
   localparam int ROUTER_W        = 4;
   localparam int WORD_W          = 32;
   localparam int STATUS_W        = 2;

   localparam logic [NUM_W-1:0] NUM_ROUTERS_RST = NUM_W'(16);

   // request kinds
   localparam logic REQ_SEND = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_CONN  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NONE_LEFT = 2'd2;

   typedef struct packed {
      logic                req_type;
      logic [ROUTER_W-1:0] router;
      logic                send_valid;
      logic [WORD_W-1:0]   send_value;
      logic                drop;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                bus_valid;
      logic [WORD_W-1:0]   bus_data;
      logic [ROUTER_W-1:0] winner_router;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic init_step;
      logic set_nc;
      logic set_none;
      logic send_write;
      logic scan_step;
      logic addr_last;
      logic win_capture;
      logic drop_move;
      logic finish;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic init_last;
      logic is_tick;
      logic known;
      logic count_zero;
      logic do_drop;
      logic hit;
      logic scan_last;
      logic rsp_free;
   } dp_status_type;

endpackage

### design/rrsb_ctrl.sv
// ----------------------------------------------------------------------------
// rrsb_ctrl: request sequencer for the round-robin shared bus
// Steps each request through decode, slot write (send), slot scan, winner
// lookup, router drop and response hand-off, and runs the map initialization sweep.
// ----------------------------------------------------------------------------
module rrsb_ctrl
   import rrsb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_fire,
   input  logic          csr_valid,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type dp_sts,
   output ctl_cmd_type   cmd
);

   typedef enum logic [10:0] {
      S_INIT    = 11'b000_0000_0001,
      S_IDLE    = 11'b000_0000_0010,
      S_DECODE  = 11'b000_0000_0100,
      S_SEND_RD = 11'b000_0000_1000,
      S_SEND_WR = 11'b000_0001_0000,
      S_SCAN    = 11'b000_0010_0000,
      S_WIN_RD  = 11'b000_0100_0000,
      S_WIN_CAP = 11'b000_1000_0000,
      S_DROP_RD = 11'b001_0000_0000,
      S_DROP_MV = 11'b010_0000_0000,
      S_FINISH  = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   state_type drop_next;
   logic      drop_nc;

   // where a tick goes once arbitration is settled
   always_comb begin
      drop_nc   = 1'b0;
      drop_next = S_FINISH;
      if (dp_sts.do_drop) begin
         if (dp_sts.known) begin
            drop_next = S_DROP_RD;
         end else begin
            drop_nc = 1'b1;
         end
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (dp_sts.init_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid && !csr_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!dp_sts.is_tick) begin
               if (dp_sts.known) begin
                  state_in = S_SEND_RD;
               end else begin
                  cmd.set_nc = 1'b1;
                  state_in   = S_FINISH;
               end
            end else if (dp_sts.count_zero) begin
               cmd.set_none = 1'b1;
               state_in     = S_FINISH;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SEND_RD: begin
            state_in = S_SEND_WR;
         end
         S_SEND_WR: begin
            cmd.send_write = 1'b1;
            state_in       = S_FINISH;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (dp_sts.hit) begin
               state_in = S_WIN_RD;
            end else if (dp_sts.scan_last) begin
               cmd.set_nc = drop_nc;
               state_in   = drop_next;
            end
         end
         S_WIN_RD: begin
            state_in = S_WIN_CAP;
         end
         S_WIN_CAP: begin
            cmd.win_capture = 1'b1;
            cmd.set_nc      = drop_nc;
            state_in        = drop_next;
         end
         S_DROP_RD: begin
            cmd.addr_last = 1'b1;
            state_in      = S_DROP_MV;
         end
         S_DROP_MV: begin
            cmd.drop_move = 1'b1;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            if (dp_sts.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
      if (csr_fire) begin
         state_in = S_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE) || csr_valid;

endmodule

### design/rrsb_dpath.sv
// ----------------------------------------------------------------------------
// rrsb_dpath: slot storage and arbitration datapath
// Holds slot words, slot/router maps, full and connected bits, the active
// count, the round-robin pointer and the response register.
// ----------------------------------------------------------------------------
module rrsb_dpath
   import rrsb_pkg::*;
#(
   parameter int MAX_ROUTERS = MAX_ROUTERS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_fire,
   input  logic [NUM_W-1:0] csr_data,
   input  req_payload_type req_data,
   input  ctl_cmd_type     cmd,
   output dp_status_type   dp_sts,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   localparam int SLOT_W = $clog2(MAX_ROUTERS);
   localparam int CNT_W  = $clog2(MAX_ROUTERS + 1);

   // memories
   logic [WORD_W-1:0] slot_word_ff   [MAX_ROUTERS];
   logic [SLOT_W-1:0] slot_owner_ff  [MAX_ROUTERS];
   logic [SLOT_W-1:0] router_slot_ff [MAX_ROUTERS];
   logic [WORD_W-1:0] word_rd_ff;
   logic [SLOT_W-1:0] owner_rd_ff;
   logic [SLOT_W-1:0] rs_rd_ff;

   // per-slot and per-router bits
   logic [MAX_ROUTERS-1:0] full_ff;
   logic [MAX_ROUTERS-1:0] full_in;
   logic [MAX_ROUTERS-1:0] conn_ff;

   // control and scan state
   req_payload_type req_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [SLOT_W-1:0] next_ff;
   logic [SLOT_W-1:0] init_cnt_ff;
   logic [SLOT_W-1:0] idx_ff;
   logic [CNT_W-1:0]  scan_cnt_ff;
   logic [SLOT_W-1:0] win_ff;
   logic              granted_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [WORD_W-1:0]   bus_data_ff;
   logic [ROUTER_W-1:0] winner_ff;
   logic              rsp_valid_ff;
   rsp_payload_type   rsp_ff;

   logic [NUM_W-1:0]  n_raw;
   logic [CNT_W-1:0]  n_sat;
   logic [SLOT_W-1:0] r_idx;
   logic [SLOT_W-1:0] last_slot;
   logic [SLOT_W-1:0] word_addr;
   logic              in_range;
   logic [SLOT_W-1:0] idx_red;
   logic              hit;
   logic [SLOT_W-1:0] idx_next;
   logic [CNT_W-1:0]  win_inc;
   logic [SLOT_W-1:0] next_grant;
   logic              known;
   logic              move_en;
   logic              rsp_free;

   // router count after reset or a register write, clamped to 1..MAX_ROUTERS
   assign n_raw = reset ? NUM_ROUTERS_RST : csr_data;
   always_comb begin
      if (n_raw == '0) begin
         n_sat = CNT_W'(1);
      end else if (int'(n_raw) > MAX_ROUTERS) begin
         n_sat = CNT_W'(MAX_ROUTERS);
      end else begin
         n_sat = CNT_W'(n_raw);
      end
   end

   // addressing
   assign r_idx     = SLOT_W'(req_ff.router);
   assign known     = (int'(req_ff.router) < MAX_ROUTERS) && conn_ff[r_idx];
   assign last_slot = SLOT_W'(count_ff - CNT_W'(1));
   assign word_addr = cmd.addr_last ? last_slot : win_ff;
   assign move_en   = cmd.drop_move && (rs_rd_ff != last_slot);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // scan start: the raw pointer is brought below the active count by
   // subtracting the count once per cycle, then slots are checked in order
   assign in_range = (CNT_W'(idx_ff) < count_ff);
   assign idx_red  = SLOT_W'(CNT_W'(idx_ff) - count_ff);
   assign hit      = in_range && full_ff[idx_ff];
   assign idx_next = (CNT_W'(idx_ff) + CNT_W'(1) == count_ff) ? '0 : idx_ff + SLOT_W'(1);

   // pointer after a grant: (win + 1) mod count
   assign win_inc = CNT_W'(win_ff) + CNT_W'(1);
   always_comb begin
      if (count_ff <= CNT_W'(1)) begin
         next_grant = '0;
      end else if (win_inc >= count_ff) begin
         next_grant = SLOT_W'(win_inc - count_ff);
      end else begin
         next_grant = SLOT_W'(win_inc);
      end
   end

   // slot word memory
   always_ff @(posedge clock) begin
      if (cmd.send_write) begin
         slot_word_ff[rs_rd_ff] <= req_ff.send_valid ? req_ff.send_value : '0;
      end else if (move_en) begin
         slot_word_ff[rs_rd_ff] <= word_rd_ff;
      end
      word_rd_ff <= slot_word_ff[word_addr];
   end

   // slot owner memory (router in each active slot)
   always_ff @(posedge clock) begin
      if (cmd.init_step) begin
         slot_owner_ff[init_cnt_ff] <= init_cnt_ff;
      end else if (move_en) begin
         slot_owner_ff[rs_rd_ff] <= owner_rd_ff;
      end
      owner_rd_ff <= slot_owner_ff[word_addr];
   end

   // router slot memory
   always_ff @(posedge clock) begin
      if (cmd.init_step) begin
         router_slot_ff[init_cnt_ff] <= init_cnt_ff;
      end else if (move_en) begin
         router_slot_ff[owner_rd_ff] <= rs_rd_ff;
      end
      rs_rd_ff <= router_slot_ff[r_idx];
   end

   // next full bits: send writes the slot, drop pulls the last slot in
   always_comb begin
      full_in = full_ff;
      if (cmd.send_write) begin
         full_in[rs_rd_ff] = req_ff.send_valid;
      end
      if (cmd.drop_move) begin
         if (move_en) begin
            full_in[rs_rd_ff] = full_ff[last_slot];
         end
         full_in[last_slot] = 1'b0;
      end
   end

   // bus state
   always_ff @(posedge clock) begin
      if (reset || csr_fire) begin
         full_ff     <= '0;
         count_ff    <= n_sat;
         next_ff     <= '0;
         init_cnt_ff <= '0;
         for (int i = 0; i < MAX_ROUTERS; i++) begin
            conn_ff[i] <= (i < int'(n_sat));
         end
      end else begin
         full_ff <= full_in;
         if (cmd.init_step) begin
            init_cnt_ff <= init_cnt_ff + SLOT_W'(1);
         end
         if (cmd.drop_move) begin
            conn_ff[r_idx] <= 1'b0;
            count_ff       <= count_ff - CNT_W'(1);
         end
         if (cmd.finish && req_ff.req_type == REQ_TICK) begin
            if (granted_ff) begin
               next_ff <= next_grant;
            end else if (count_ff == '0) begin
               next_ff <= '0;
            end
         end
      end
   end

   // request latch and scan
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff      <= req_data;
         idx_ff      <= next_ff;
         scan_cnt_ff <= '0;
         status_ff   <= STATUS_OK;
         bus_data_ff <= '0;
         winner_ff   <= '0;
      end
      if (cmd.scan_step) begin
         if (!in_range) begin
            idx_ff <= idx_red;
         end else if (!full_ff[idx_ff]) begin
            idx_ff      <= idx_next;
            scan_cnt_ff <= scan_cnt_ff + CNT_W'(1);
         end
         win_ff <= idx_ff;
      end
      if (cmd.win_capture) begin
         bus_data_ff <= word_rd_ff;
         winner_ff   <= ROUTER_W'(owner_rd_ff);
      end
      if (cmd.set_nc) begin
         status_ff <= STATUS_NOT_CONN;
      end else if (cmd.set_none) begin
         status_ff <= STATUS_NONE_LEFT;
      end
   end

   // grant flag
   always_ff @(posedge clock) begin
      if (reset || cmd.accept) begin
         granted_ff <= 1'b0;
      end else if (cmd.scan_step && hit) begin
         granted_ff <= 1'b1;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         rsp_ff.status        <= status_ff;
         rsp_ff.bus_valid     <= granted_ff;
         rsp_ff.bus_data      <= bus_data_ff;
         rsp_ff.winner_router <= winner_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // status to controller
   assign dp_sts.init_last  = (init_cnt_ff == SLOT_W'(MAX_ROUTERS - 1));
   assign dp_sts.is_tick    = (req_ff.req_type == REQ_TICK);
   assign dp_sts.known      = known;
   assign dp_sts.count_zero = (count_ff == '0);
   assign dp_sts.do_drop    = req_ff.drop;
   assign dp_sts.hit        = hit;
   assign dp_sts.scan_last  = in_range && (scan_cnt_ff == count_ff - CNT_W'(1));
   assign dp_sts.rsp_free   = rsp_free;

endmodule

### design/round_robin_shared_bus.sv
// ----------------------------------------------------------------------------
// round_robin_shared_bus: shared bus with round-robin grant
// Routers post words into their slots; a tick request grants one full slot.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : request channel (valid/stall). A send request stores a router's
//            word in its slot; a tick request arbitrates and may drop a router.
//   rsp_*  : one response per request (valid/stall), from an output register.
//   csr_*  : write of the router count (valid/ready, always ready); it
//            restarts the bus. Write it only while no request is in flight.
// Sequence: a send reads the router's slot map entry and writes the word;
// an unknown router is answered not-connected without a write. A tick
// with no routers left is answered none-left. Otherwise the pointer is
// first brought below the active count, then slots are checked in order
// (one reduction step or one slot per cycle); on a grant the winner's word
// and router are read, and a dropped router's slot is refilled from the last.
// The response is valid by the time the next request can be taken.
// After reset and after each count write, an init sweep over all MAX_ROUTERS
// map entries loads the slot maps; requests are stalled meanwhile.
// A stalled response holds; the next request is still taken, but its
// response waits in the sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module round_robin_shared_bus
   import rrsb_pkg::*;
#(
   parameter int MAX_ROUTERS = MAX_ROUTERS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_payload_type  req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_payload_type  rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [NUM_W-1:0] csr_data
);

   ctl_cmd_type   cmd;
   dp_status_type dp_sts;
   logic          csr_fire;

   // register write port is always open
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   rrsb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_fire  (csr_fire),
      .csr_valid (csr_valid),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_sts    (dp_sts),
      .cmd       (cmd)
   );

   rrsb_dpath #(
      .MAX_ROUTERS (MAX_ROUTERS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_fire  (csr_fire),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .dp_sts    (dp_sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
